// ===== rtl/dcsd_pkg.sv =====
package dcsd_pkg;

   typedef struct packed {
      logic       second_pulse;
      logic       millisecond_pulse;
      logic [1:0] set_button;
      logic [1:0] up_button;
      logic [1:0] down_button;
   } req_word_type;

   typedef struct packed {
      logic [7:0] flash_period_ms;
      logic [7:0] repeat_period_ms;
   } cfg_type;

   localparam logic [1:0] BTN_PRESS = 2'd1;
   localparam logic [1:0] BTN_HOLD  = 2'd2;

   localparam logic CSR_FLASH_PERIOD  = 1'b0;
   localparam logic CSR_REPEAT_PERIOD = 1'b1;

   localparam logic [7:0] FLASH_PERIOD_RESET  = 8'd250;
   localparam logic [7:0] REPEAT_PERIOD_RESET = 8'd100;

   localparam logic [5:0] SECONDS_PER_MINUTE = 6'd60;
   localparam logic [5:0] MINUTES_PER_HOUR   = 6'd60;
   localparam logic [5:0] HOURS_PER_DAY      = 6'd24;

   localparam logic [3:0] MASK_LEFT_PAIR  = 4'h3;
   localparam logic [3:0] MASK_RIGHT_PAIR = 4'hC;
   localparam logic [3:0] MASK_ALL_ON     = 4'hF;

   function automatic logic [6:0] seg_pattern(input logic [3:0] digit);
      logic [6:0] pattern;
      case (digit)
         4'd0: pattern = 7'h40;
         4'd1: pattern = 7'h79;
         4'd2: pattern = 7'h24;
         4'd3: pattern = 7'h30;
         4'd4: pattern = 7'h19;
         4'd5: pattern = 7'h12;
         4'd6: pattern = 7'h02;
         4'd7: pattern = 7'h78;
         4'd8: pattern = 7'h00;
         4'd9: pattern = 7'h18;
         default: pattern = 7'h40;
      endcase
      return pattern;
   endfunction

endpackage

// ===== rtl/dcsd_digit_decode.sv =====
module dcsd_digit_decode (
   input  logic [5:0] value,
   input  logic       tens,
   output logic [6:0] segments
);
   import dcsd_pkg::*;

   logic [13:0] product;
   logic [2:0]  tens_digit;
   logic [5:0]  ones_full;
   logic [3:0]  digit;

   // Multiplying by 205 and dropping 11 bits divides by ten for all six-bit values.
   assign product    = {8'd0, value} * 14'd205;
   assign tens_digit = product[13:11];
   assign ones_full  = value - ({3'b000, tens_digit} * 6'd10);
   assign digit      = tens ? {1'b0, tens_digit} : ones_full[3:0];
   assign segments   = seg_pattern(digit);

endmodule

// ===== rtl/dcsd_state.sv =====
module dcsd_state (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  fire,
   input  dcsd_pkg::req_word_type word,
   input  dcsd_pkg::cfg_type      cfg,
   output logic [6:0]            segment_lines,
   output logic [3:0]            digit_enables,
   output logic [4:0]            hours_now,
   output logic [5:0]            minutes_now,
   output logic [5:0]            seconds_now,
   output logic [2:0]            clock_mode
);
   import dcsd_pkg::*;

   typedef enum logic [2:0] {
      MODE_HM,
      MODE_MS,
      MODE_SET_H,
      MODE_SET_M,
      MODE_MS_SET_M,
      MODE_MS_SET_S
   } mode_type;

   typedef struct packed {
      logic [5:0] hours;
      logic [5:0] minutes;
      logic [5:0] seconds;
   } time_type;

   function automatic logic [5:0] wrap_up(input logic [5:0] v, input logic [5:0] limit);
      logic [5:0] nxt;
      nxt = v + 6'd1;
      return (nxt >= limit) ? 6'd0 : nxt;
   endfunction

   function automatic logic [5:0] wrap_down(input logic [5:0] v, input logic [5:0] limit);
      return (v == 6'd0 || v >= limit) ? limit - 6'd1 : v - 6'd1;
   endfunction

   function automatic time_type step_field(input mode_type mode, input logic dir,
                                           input time_type t);
      time_type r;
      r = t;
      case (mode)
         MODE_SET_H: begin
            r.hours = dir ? wrap_up(t.hours, HOURS_PER_DAY) : wrap_down(t.hours, HOURS_PER_DAY);
         end
         MODE_SET_M, MODE_MS_SET_M: begin
            r.minutes = dir ? wrap_up(t.minutes, MINUTES_PER_HOUR)
                            : wrap_down(t.minutes, MINUTES_PER_HOUR);
         end
         MODE_MS_SET_S: begin
            r.seconds = dir ? wrap_up(t.seconds, SECONDS_PER_MINUTE)
                            : wrap_down(t.seconds, SECONDS_PER_MINUTE);
         end
         default: r = t;
      endcase
      return r;
   endfunction

   logic [4:0] hours_ff, hours_in;
   logic [5:0] minutes_ff, minutes_in;
   logic [5:0] seconds_ff, seconds_in;
   mode_type   mode_ff, mode_in;
   logic [7:0] flash_count_ff, flash_count_in;
   logic [7:0] repeat_count_ff, repeat_count_in;
   logic [3:0] blank_mask_ff, blank_mask_in;
   logic [1:0] digit_pointer_ff, digit_pointer_in;
   logic [6:0] segment_ff, segment_in;
   logic [3:0] enable_ff, enable_in;

   time_type   time_ticked;
   logic [7:0] repeat_ticked;
   logic [5:0] disp_value;
   logic       disp_tens;
   logic [6:0] disp_pattern;

   always_comb begin
      logic [5:0] sec_next;
      logic [5:0] min_next;
      logic [5:0] hour_next;
      logic       ms_view;
      logic [5:0] left_value;
      logic [5:0] right_value;

      sec_next  = seconds_ff;
      min_next  = minutes_ff;
      hour_next = {1'b0, hours_ff};
      if (word.second_pulse && (mode_ff == MODE_HM || mode_ff == MODE_MS)) begin
         sec_next = seconds_ff + 6'd1;
         if (sec_next >= SECONDS_PER_MINUTE) begin
            sec_next = 6'd0;
            min_next = minutes_ff + 6'd1;
         end
         if (min_next >= MINUTES_PER_HOUR) begin
            min_next  = 6'd0;
            hour_next = {1'b0, hours_ff} + 6'd1;
         end
         if (hour_next >= HOURS_PER_DAY) begin
            hour_next = 6'd0;
         end
      end
      time_ticked = '{hours: hour_next, minutes: min_next, seconds: sec_next};

      flash_count_in = flash_count_ff + {7'd0, word.millisecond_pulse};
      repeat_ticked  = repeat_count_ff + {7'd0, word.millisecond_pulse};
      blank_mask_in  = blank_mask_ff;
      if (flash_count_in == cfg.flash_period_ms) begin
         flash_count_in = 8'd0;
         case (mode_ff)
            MODE_SET_H, MODE_MS_SET_M: blank_mask_in = ~(blank_mask_ff & MASK_LEFT_PAIR);
            MODE_SET_M, MODE_MS_SET_S: blank_mask_in = ~(blank_mask_ff & MASK_RIGHT_PAIR);
            default: blank_mask_in = MASK_ALL_ON;
         endcase
      end

      ms_view = (mode_ff == MODE_MS || mode_ff == MODE_MS_SET_M || mode_ff == MODE_MS_SET_S);
      left_value  = ms_view ? time_ticked.minutes : time_ticked.hours;
      right_value = ms_view ? time_ticked.seconds : time_ticked.minutes;
      disp_value  = digit_pointer_ff[1] ? right_value : left_value;
      disp_tens   = ~digit_pointer_ff[0];

      if (word.millisecond_pulse) begin
         enable_in        = (4'b0001 << digit_pointer_ff) & blank_mask_in;
         digit_pointer_in = digit_pointer_ff + 2'd1;
      end else begin
         enable_in        = enable_ff;
         digit_pointer_in = digit_pointer_ff;
      end
   end

   dcsd_digit_decode u_digit_decode (
      .value    (disp_value),
      .tens     (disp_tens),
      .segments (disp_pattern)
   );

   always_comb begin
      time_type   t;
      logic       set_mode;
      logic [7:0] rc;

      segment_in = word.millisecond_pulse ? disp_pattern : segment_ff;

      mode_in = mode_ff;
      if (word.set_button == BTN_PRESS || word.set_button == BTN_HOLD) begin
         case (mode_ff)
            MODE_HM:       mode_in = (word.set_button == BTN_HOLD) ? MODE_SET_H : MODE_MS;
            MODE_MS:       mode_in = (word.set_button == BTN_HOLD) ? MODE_MS_SET_M : MODE_HM;
            MODE_SET_H:    mode_in = MODE_SET_M;
            MODE_SET_M:    mode_in = MODE_HM;
            MODE_MS_SET_M: mode_in = MODE_MS_SET_S;
            MODE_MS_SET_S: mode_in = MODE_MS;
            default:       mode_in = MODE_HM;
         endcase
      end

      set_mode = (mode_in == MODE_SET_H || mode_in == MODE_SET_M ||
                  mode_in == MODE_MS_SET_M || mode_in == MODE_MS_SET_S);
      t  = time_ticked;
      rc = repeat_ticked;

      if (word.up_button == BTN_PRESS) begin
         t = step_field(mode_in, 1'b1, t);
      end else if (word.up_button == BTN_HOLD && set_mode && rc == cfg.repeat_period_ms) begin
         rc = 8'd0;
         t  = step_field(mode_in, 1'b1, t);
      end

      if (word.down_button == BTN_PRESS) begin
         t = step_field(mode_in, 1'b0, t);
      end else if (word.down_button == BTN_HOLD && set_mode && rc == cfg.repeat_period_ms) begin
         rc = 8'd0;
         t  = step_field(mode_in, 1'b0, t);
      end

      repeat_count_in = rc;
      hours_in        = t.hours[4:0];
      minutes_in      = t.minutes;
      seconds_in      = t.seconds;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hours_ff         <= 5'd0;
         minutes_ff       <= 6'd0;
         seconds_ff       <= 6'd0;
         mode_ff          <= MODE_HM;
         flash_count_ff   <= 8'd0;
         repeat_count_ff  <= 8'd0;
         blank_mask_ff    <= MASK_ALL_ON;
         digit_pointer_ff <= 2'd0;
         segment_ff       <= 7'd0;
         enable_ff        <= 4'd0;
      end else if (fire) begin
         hours_ff         <= hours_in;
         minutes_ff       <= minutes_in;
         seconds_ff       <= seconds_in;
         mode_ff          <= mode_in;
         flash_count_ff   <= flash_count_in;
         repeat_count_ff  <= repeat_count_in;
         blank_mask_ff    <= blank_mask_in;
         digit_pointer_ff <= digit_pointer_in;
         segment_ff       <= segment_in;
         enable_ff        <= enable_in;
      end
   end

   assign segment_lines = segment_ff;
   assign digit_enables = enable_ff;
   assign hours_now     = hours_ff;
   assign minutes_now   = minutes_ff;
   assign seconds_now   = seconds_ff;
   assign clock_mode    = mode_ff;

endmodule

// ===== rtl/digital_clock_set_display.sv =====
// A word accepted on the request side is held in the input register; when the response
// side is free, the state update writes the response registers that offer it.
// Throughput: one word per cycle while the response side does not stall; the state
// registers double as the response register.
// Reset is synchronous and active high: time, mode, counters and display go to zero,
// the blanking mask to all on, and the periods to 250 ms and 100 ms.
module digital_clock_set_display (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_second_pulse,
   input  logic       req_millisecond_pulse,
   input  logic [1:0] req_set_button,
   input  logic [1:0] req_up_button,
   input  logic [1:0] req_down_button,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [6:0] rsp_segment_lines,
   output logic [3:0] rsp_digit_enables,
   output logic [4:0] rsp_hours_now,
   output logic [5:0] rsp_minutes_now,
   output logic [5:0] rsp_seconds_now,
   output logic [2:0] rsp_clock_mode,
   input  logic       csr_write_enable,
   input  logic       csr_index,
   input  logic [7:0] csr_write_data
);
   import dcsd_pkg::*;

   req_word_type word_ff, word_in;
   logic         word_valid_ff, word_valid_in;
   logic         rsp_valid_ff, rsp_valid_in;
   cfg_type      cfg_ff, cfg_in;
   logic         fire;
   logic         req_accept;

   assign fire       = word_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall  = word_valid_ff && !fire;
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      word_in = req_accept ? req_word_type'{second_pulse:      req_second_pulse,
                                            millisecond_pulse: req_millisecond_pulse,
                                            set_button:        req_set_button,
                                            up_button:         req_up_button,
                                            down_button:       req_down_button} : word_ff;
      word_valid_in = req_accept || (word_valid_ff && !fire);
      rsp_valid_in  = fire || (rsp_valid_ff && rsp_stall);

      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_FLASH_PERIOD:  cfg_in.flash_period_ms  = csr_write_data;
            CSR_REPEAT_PERIOD: cfg_in.repeat_period_ms = csr_write_data;
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         word_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         cfg_ff        <= '{flash_period_ms:  FLASH_PERIOD_RESET,
                            repeat_period_ms: REPEAT_PERIOD_RESET};
      end else begin
         word_valid_ff <= word_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         cfg_ff        <= cfg_in;
      end
      word_ff <= word_in;
   end

   dcsd_state u_state (
      .clock         (clock),
      .reset         (reset),
      .fire          (fire),
      .word          (word_ff),
      .cfg           (cfg_ff),
      .segment_lines (rsp_segment_lines),
      .digit_enables (rsp_digit_enables),
      .hours_now     (rsp_hours_now),
      .minutes_now   (rsp_minutes_now),
      .seconds_now   (rsp_seconds_now),
      .clock_mode    (rsp_clock_mode)
   );

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== rtl/dcsd_checker.sv =====
module dcsd_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [6:0] rsp_segment_lines,
   input logic [3:0] rsp_digit_enables,
   input logic [4:0] rsp_hours_now,
   input logic [5:0] rsp_minutes_now,
   input logic [5:0] rsp_seconds_now,
   input logic [2:0] rsp_clock_mode
);

   // A stalled response word holds its payload until it is taken.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_segment_lines) &&
         $stable(rsp_digit_enables) && $stable(rsp_hours_now) &&
         $stable(rsp_minutes_now) && $stable(rsp_seconds_now) && $stable(rsp_clock_mode))
      else $error("stalled response word changed");

   // At most one digit is driven at a time.
   assert property (@(posedge clock) disable iff (reset) $onehot0(rsp_digit_enables))
      else $error("more than one digit enabled");

   // The time fields stay within a 24-hour day.
   assert property (@(posedge clock) disable iff (reset)
      rsp_hours_now <= 5'd23 && rsp_minutes_now <= 6'd59 && rsp_seconds_now <= 6'd59)
      else $error("time field out of range");

   // Without a new response word the visible state does not move.
   assert property (@(posedge clock) disable iff (reset)
      !reset && !rsp_valid ##1 !rsp_valid |-> $stable(rsp_hours_now) &&
         $stable(rsp_minutes_now) && $stable(rsp_seconds_now) && $stable(rsp_clock_mode) &&
         $stable(rsp_digit_enables) && $stable(rsp_segment_lines))
      else $error("state changed without a response word");

endmodule

bind digital_clock_set_display dcsd_checker u_checker (.*);

// ===== tb/tb_digital_clock_set_display.sv =====
import dcsd_pkg::*;

typedef enum logic [2:0] {
   MODE_HHMM             = 3'd0,
   MODE_MMSS             = 3'd1,
   MODE_SET_HOURS        = 3'd2,
   MODE_SET_MINUTES      = 3'd3,
   MODE_MMSS_SET_MINUTES = 3'd4,
   MODE_MMSS_SET_SECONDS = 3'd5
} clock_mode_type;

localparam logic [1:0] BTN_NONE    = 2'd0;
localparam logic [1:0] BTN_INVALID = 2'd3;

localparam logic [6:0] DIGIT_SEGMENTS [0:9] = '{
   7'h40, 7'h79, 7'h24, 7'h30, 7'h19, 7'h12, 7'h02, 7'h78, 7'h00, 7'h18
};

typedef struct packed {
   logic [6:0] segment_lines;
   logic [3:0] digit_enables;
   logic [4:0] hours_now;
   logic [5:0] minutes_now;
   logic [5:0] seconds_now;
   logic [2:0] clock_mode;
} display_word_type;

class clock_display_scoreboard;
   display_word_type expected_displays[$];
   int errors;

   logic [7:0] flash_period;
   logic [7:0] repeat_period;
   int hours;
   int minutes;
   int seconds;
   logic [2:0] mode_state;
   logic [7:0] flash_count;
   logic [7:0] repeat_count;
   logic [7:0] blank_mask;
   logic [1:0] digit_pointer;
   logic [6:0] segment_value;
   logic [3:0] enable_value;

   function new();
      errors = 0;
      flash_period = FLASH_PERIOD_RESET;
      repeat_period = REPEAT_PERIOD_RESET;
      hours = 0;
      minutes = 0;
      seconds = 0;
      mode_state = MODE_HHMM;
      flash_count = 8'd0;
      repeat_count = 8'd0;
      blank_mask = 8'hFF;
      digit_pointer = 2'd0;
      segment_value = 7'd0;
      enable_value = 4'd0;
   endfunction

   function void write_reg(logic index, logic [7:0] value);
      if (index == CSR_FLASH_PERIOD) begin
         flash_period = value;
      end else begin
         repeat_period = value;
      end
   endfunction

   function int pending();
      return expected_displays.size();
   endfunction

   function int wrap_step(int value, int limit, bit up);
      if (up) begin
         return (value + 1 >= limit) ? 0 : value + 1;
      end
      return (value == 0 || value >= limit) ? limit - 1 : value - 1;
   endfunction

   function void step_field(bit up);
      case (mode_state)
         MODE_SET_HOURS: hours = wrap_step(hours, HOURS_PER_DAY, up);
         MODE_SET_MINUTES, MODE_MMSS_SET_MINUTES: begin
            minutes = wrap_step(minutes, MINUTES_PER_HOUR, up);
         end
         MODE_MMSS_SET_SECONDS: seconds = wrap_step(seconds, SECONDS_PER_MINUTE, up);
         default: ;
      endcase
   endfunction

   function void apply_button(logic [1:0] code, bit up);
      if (code == BTN_PRESS) begin
         step_field(up);
      end else if (code == BTN_HOLD && mode_state >= MODE_SET_HOURS &&
                   mode_state <= MODE_MMSS_SET_SECONDS && repeat_count == repeat_period) begin
         repeat_count = 8'd0;
         step_field(up);
      end
   endfunction

   function void note_word(req_word_type w);
      display_word_type d;
      bit ms_view;
      bit hold;
      int left;
      int right;
      if (w.second_pulse && (mode_state == MODE_HHMM || mode_state == MODE_MMSS)) begin
         seconds = seconds + 1;
         if (seconds >= SECONDS_PER_MINUTE) begin
            seconds = 0;
            minutes = minutes + 1;
         end
         if (minutes >= MINUTES_PER_HOUR) begin
            minutes = 0;
            hours = hours + 1;
         end
         if (hours >= HOURS_PER_DAY) hours = 0;
      end
      if (w.millisecond_pulse) begin
         flash_count = flash_count + 8'd1;
         repeat_count = repeat_count + 8'd1;
      end
      if (flash_count == flash_period) begin
         flash_count = 8'd0;
         case (mode_state)
            MODE_SET_HOURS, MODE_MMSS_SET_MINUTES: begin
               blank_mask = ~(blank_mask & {4'h0, MASK_LEFT_PAIR});
            end
            MODE_SET_MINUTES, MODE_MMSS_SET_SECONDS: begin
               blank_mask = ~(blank_mask & {4'h0, MASK_RIGHT_PAIR});
            end
            default: blank_mask = 8'hFF;
         endcase
      end
      if (w.millisecond_pulse) begin
         ms_view = (mode_state == MODE_MMSS || mode_state == MODE_MMSS_SET_MINUTES ||
                    mode_state == MODE_MMSS_SET_SECONDS);
         left = ms_view ? minutes : hours;
         right = ms_view ? seconds : minutes;
         case (digit_pointer)
            2'd0: segment_value = DIGIT_SEGMENTS[left / 10];
            2'd1: segment_value = DIGIT_SEGMENTS[left % 10];
            2'd2: segment_value = DIGIT_SEGMENTS[right / 10];
            default: segment_value = DIGIT_SEGMENTS[right % 10];
         endcase
         enable_value = (4'b0001 << digit_pointer) & blank_mask[3:0];
         digit_pointer = digit_pointer + 2'd1;
      end
      if (w.set_button == BTN_PRESS || w.set_button == BTN_HOLD) begin
         hold = (w.set_button == BTN_HOLD);
         case (mode_state)
            MODE_HHMM: mode_state = hold ? MODE_SET_HOURS : MODE_MMSS;
            MODE_MMSS: mode_state = hold ? MODE_MMSS_SET_MINUTES : MODE_HHMM;
            MODE_SET_HOURS: mode_state = MODE_SET_MINUTES;
            MODE_SET_MINUTES: mode_state = MODE_HHMM;
            MODE_MMSS_SET_MINUTES: mode_state = MODE_MMSS_SET_SECONDS;
            MODE_MMSS_SET_SECONDS: mode_state = MODE_MMSS;
            default: mode_state = MODE_HHMM;
         endcase
      end
      apply_button(w.up_button, 1'b1);
      apply_button(w.down_button, 1'b0);
      d.segment_lines = segment_value;
      d.digit_enables = enable_value;
      d.hours_now = hours[4:0];
      d.minutes_now = minutes[5:0];
      d.seconds_now = seconds[5:0];
      d.clock_mode = mode_state;
      expected_displays.push_back(d);
   endfunction

   function void compare_field(string name, int expected, int actual);
      if (expected != actual) begin
         $error("%s: expected %0d, got %0d", name, expected, actual);
         errors++;
      end
   endfunction

   function void check_display(display_word_type actual);
      display_word_type e;
      if (expected_displays.size() == 0) begin
         $error("result word with no expectation waiting");
         errors++;
      end else begin
         e = expected_displays.pop_front();
         compare_field("segment_lines", e.segment_lines, actual.segment_lines);
         compare_field("digit_enables", e.digit_enables, actual.digit_enables);
         compare_field("hours_now", e.hours_now, actual.hours_now);
         compare_field("minutes_now", e.minutes_now, actual.minutes_now);
         compare_field("seconds_now", e.seconds_now, actual.seconds_now);
         compare_field("clock_mode", e.clock_mode, actual.clock_mode);
      end
   endfunction
endclass

module tb_digital_clock_set_display;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int SEGMENT_ITEMS = 75;
   localparam int SEGMENT_COUNT = 6;
   localparam logic [7:0] FLASH_SETTINGS [0:SEGMENT_COUNT-1] = '{
      8'd1, 8'd255, 8'd0, 8'd4, 8'd250, 8'd2
   };
   localparam logic [7:0] REPEAT_SETTINGS [0:SEGMENT_COUNT-1] = '{
      8'd1, 8'd255, 8'd0, 8'd3, 8'd100, 8'd9
   };

   logic clock;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_word_type req_word = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [6:0] rsp_segment_lines;
   logic [3:0] rsp_digit_enables;
   logic [4:0] rsp_hours_now;
   logic [5:0] rsp_minutes_now;
   logic [5:0] rsp_seconds_now;
   logic [2:0] rsp_clock_mode;
   logic csr_write_enable = 1'b0;
   logic csr_index = 1'b0;
   logic [7:0] csr_write_data = 8'd0;

   int tx_idle_pct = 31;
   int rx_idle_pct = 66;
   int stuck_cycles = 0;
   bit up_held = 1'b0;
   bit down_held = 1'b0;
   clock_display_scoreboard sb = new();

   digital_clock_set_display i_dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_second_pulse      (req_word.second_pulse),
      .req_millisecond_pulse (req_word.millisecond_pulse),
      .req_set_button        (req_word.set_button),
      .req_up_button         (req_word.up_button),
      .req_down_button       (req_word.down_button),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_segment_lines     (rsp_segment_lines),
      .rsp_digit_enables     (rsp_digit_enables),
      .rsp_hours_now         (rsp_hours_now),
      .rsp_minutes_now       (rsp_minutes_now),
      .rsp_seconds_now       (rsp_seconds_now),
      .rsp_clock_mode        (rsp_clock_mode),
      .csr_write_enable      (csr_write_enable),
      .csr_index             (csr_index),
      .csr_write_data        (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < rx_idle_pct);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            sb.note_word(req_word);
         end
         if (rsp_valid && !rsp_stall) begin
            sb.check_display({rsp_segment_lines, rsp_digit_enables, rsp_hours_now,
                              rsp_minutes_now, rsp_seconds_now, rsp_clock_mode});
         end
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            stuck_cycles <= 0;
         end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
         end else begin
            stuck_cycles <= stuck_cycles + 1;
         end
      end
   end

   function automatic req_word_type mk_word(bit sec, bit ms, logic [1:0] set_code,
                                            logic [1:0] up_code, logic [1:0] down_code);
      req_word_type w;
      w.second_pulse = sec;
      w.millisecond_pulse = ms;
      w.set_button = set_code;
      w.up_button = up_code;
      w.down_button = down_code;
      return w;
   endfunction

   function automatic logic [1:0] random_level(bit held);
      int r;
      r = $urandom_range(99);
      if (held) begin
         return (r < 3) ? BTN_INVALID : BTN_HOLD;
      end
      if (r < 8) return BTN_PRESS;
      if (r < 10) return BTN_INVALID;
      return BTN_NONE;
   endfunction

   task automatic next_random_word(output req_word_type w);
      int r;
      if ($urandom_range(11) == 0) up_held = !up_held;
      if ($urandom_range(11) == 0) down_held = !down_held;
      r = $urandom_range(99);
      w.second_pulse = ($urandom_range(99) < 30);
      w.millisecond_pulse = ($urandom_range(99) < 75);
      w.set_button = (r < 5) ? BTN_PRESS : (r < 10) ? BTN_HOLD :
                     (r < 12) ? BTN_INVALID : BTN_NONE;
      w.up_button = random_level(up_held);
      w.down_button = random_level(down_held);
   endtask

   task automatic send_word(req_word_type w);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word <= w;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(logic index, logic [7:0] value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= index;
      csr_write_data <= value;
      sb.write_reg(index, value);
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   initial begin
      req_word_type directed_words[$];
      req_word_type w;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      write_reg(CSR_FLASH_PERIOD, 8'd3);
      write_reg(CSR_REPEAT_PERIOD, 8'd255);

      // The set sequence walks every mode and leaves the clock at 23:59:05.
      directed_words = '{
         mk_word(0, 1, BTN_NONE, BTN_NONE, BTN_NONE),
         mk_word(1, 1, BTN_NONE, BTN_NONE, BTN_NONE),
         mk_word(1, 1, BTN_PRESS, BTN_NONE, BTN_NONE),
         mk_word(0, 1, BTN_PRESS, BTN_NONE, BTN_NONE),
         mk_word(0, 1, BTN_HOLD, BTN_NONE, BTN_NONE),
         mk_word(1, 1, BTN_NONE, BTN_NONE, BTN_PRESS),
         mk_word(0, 1, BTN_NONE, BTN_PRESS, BTN_NONE),
         mk_word(0, 1, BTN_NONE, BTN_NONE, BTN_PRESS),
         mk_word(0, 1, BTN_PRESS, BTN_NONE, BTN_PRESS),
         mk_word(0, 1, BTN_NONE, BTN_HOLD, BTN_HOLD),
         mk_word(0, 0, BTN_INVALID, BTN_INVALID, BTN_INVALID),
         mk_word(0, 1, BTN_PRESS, BTN_NONE, BTN_NONE),
         mk_word(0, 1, BTN_NONE, BTN_HOLD, BTN_HOLD),
         mk_word(0, 1, BTN_PRESS, BTN_NONE, BTN_NONE),
         mk_word(0, 1, BTN_HOLD, BTN_NONE, BTN_NONE),
         mk_word(0, 1, BTN_PRESS, BTN_NONE, BTN_NONE),
         mk_word(1, 1, BTN_NONE, BTN_NONE, BTN_PRESS),
         mk_word(0, 1, BTN_PRESS, BTN_NONE, BTN_NONE),
         mk_word(1, 1, BTN_NONE, BTN_NONE, BTN_NONE),
         mk_word(1, 0, BTN_NONE, BTN_NONE, BTN_NONE),
         mk_word(0, 1, BTN_HOLD, BTN_HOLD, BTN_HOLD),
         mk_word(0, 1, BTN_HOLD, BTN_PRESS, BTN_NONE),
         mk_word(0, 1, BTN_PRESS, BTN_NONE, BTN_NONE),
         mk_word(1, 1, BTN_INVALID, BTN_PRESS, BTN_PRESS)
      };
      foreach (directed_words[i]) send_word(directed_words[i]);

      for (int seg = 0; seg < SEGMENT_COUNT; seg++) begin
         drain_results();
         if (seg == 2) begin
            tx_idle_pct = 66;
            rx_idle_pct = 31;
         end else if (seg == 4) begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
         end
         write_reg(CSR_FLASH_PERIOD, FLASH_SETTINGS[seg]);
         write_reg(CSR_REPEAT_PERIOD, REPEAT_SETTINGS[seg]);
         repeat (SEGMENT_ITEMS) begin
            next_random_word(w);
            send_word(w);
         end
      end

      drain_results();
      repeat (8) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
